// File: src/ssrb_pkg.sv
// ----------------------------------------------------------------------------
// ssrb_pkg
// Shared types and constants of the sensor sample reassembly buffer: ring
// geometry, field widths, channel payloads, register indexes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ssrb_pkg;

   // ring geometry (depth must be a power of two)
   localparam int RING_DEPTH = 256;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int ID_WIDTH   = 16;
   localparam int AXIS_WIDTH = 16;
   localparam int NUM_PARTS  = 4;
   localparam int PART_WIDTH = 3 * AXIS_WIDTH;
   localparam int AXES_WIDTH = NUM_PARTS * PART_WIDTH;
   localparam int NACK_CAP   = 63;
   localparam int NACK_CW    = $clog2(NACK_CAP + 1);
   // wide enough for ring length, window size, reach and ready count
   localparam int CMP_W      = ((RING_AW + 1) > 9) ? (RING_AW + 1) : 9;

   localparam int CSR_AW = 2;
   localparam int CSR_DW = 16;

   localparam logic [3:0] ALL_PARTS = 4'hF;

   typedef enum logic [CSR_AW-1:0] {
      CSR_WINDOW_SIZE  = 2'd0,
      CSR_TIMEOUT      = 2'd1,
      CSR_RESEND_REACH = 2'd2
   } csr_index_type;

   localparam logic OP_PART = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic RK_NACK   = 1'b0;
   localparam logic RK_STATUS = 1'b1;

   typedef struct packed {
      logic                         opcode;
      logic [1:0]                   part_kind;
      logic                         is_resend;
      logic [ID_WIDTH-1:0]          sample_id;
      logic signed [AXIS_WIDTH-1:0] axis_x;
      logic signed [AXIS_WIDTH-1:0] axis_y;
      logic signed [AXIS_WIDTH-1:0] axis_z;
   } ssrb_req_type;

   typedef struct packed {
      logic                result_kind;
      logic [ID_WIDTH-1:0] nack_id;
      logic [3:0]          missing_mask;
      logic                window_ready;
      logic                link_lost;
      logic                sensor1_lost;
      logic                sensor2_lost;
      logic [31:0]         recovered_count;
      logic [31:0]         dropped_count;
      logic                nack_overflow;
      logic                last;
   } ssrb_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PKT,
      ST_WIN,
      ST_DROP_RD,
      ST_DROP_DO,
      ST_FIND_RD,
      ST_FIND_DO,
      ST_GAP_RD,
      ST_GAP_INIT,
      ST_GAP_CHK,
      ST_ALLOC_CHK,
      ST_ALLOC_WR,
      ST_GAP_EMIT,
      ST_SCAN_CHK,
      ST_SCAN_RD,
      ST_SCAN_EMIT,
      ST_PART_RD,
      ST_PART_WR,
      ST_FLUSH_CHK,
      ST_FINAL,
      ST_STATUS
   } ssrb_state_type;

   typedef enum logic [1:0] {
      RD_HEAD,
      RD_LAST,
      RD_IDX,
      RD_SCAN
   } ssrb_rdsel_type;

   typedef enum logic [1:0] {
      RET_WIN,
      RET_ALLOC,
      RET_FLUSH,
      RET_FINAL
   } ssrb_ret_type;

   typedef struct packed {
      logic           accept;
      logic           pkt_start;
      logic           win_dec;
      logic           clr_ready;
      logic           drop_do;
      logic           find_do;
      logic           gap_init;
      logic           g_inc;
      logic           alloc_full;
      logic           alloc_wr;
      logic           alloc_own;
      logic           scan_init;
      logic           scan_inc;
      logic           part_wr;
      logic           final_chk;
      logic           emit_gap;
      logic           emit_scan;
      logic           set_over;
      logic           emit_status;
      ssrb_rdsel_type rd_sel;
   } ssrb_cmd_type;

   typedef struct packed {
      logic ready;
      logic win_zero;
      logic found;
      logic resend;
      logic ring_empty;
      logic ring_full;
      logic g_match;
      logic scan_more;
      logic scan_need;
      logic nack_cap;
      logic out_free;
      logic sensor_bad;
      logic at_idx;
   } ssrb_stat_type;

endpackage

// File: src/ssrb_ctrl.sv
// ----------------------------------------------------------------------------
// ssrb_ctrl
// Sequencer of the reassembly buffer: walks one transaction through timeout,
// window discard, slot lookup, gap filling, re-NACK scan, part write and
// flush, issuing one datapath command set per cycle.
// ----------------------------------------------------------------------------
module ssrb_ctrl
   import ssrb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_opcode,
   output logic          req_stall,
   input  ssrb_stat_type stat,
   output ssrb_cmd_type  cmd
);

   ssrb_state_type state_ff, state_in;
   ssrb_ret_type   ret_ff, ret_in;
   logic           own_ff, own_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= RET_WIN;
         own_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         own_ff   <= own_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      own_in   = own_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_opcode == OP_TICK) ? ST_STATUS : ST_PKT;
            end
         end
         ST_PKT:  state_in = ST_WIN;
         ST_WIN: begin
            if (!stat.ready || stat.win_zero) begin
               state_in = ST_FIND_RD;
            end else begin
               ret_in   = RET_WIN;
               state_in = ST_DROP_RD;
            end
         end
         ST_DROP_RD: state_in = ST_DROP_DO;
         ST_DROP_DO: begin
            unique case (ret_ff)
               RET_WIN:   state_in = ST_WIN;
               RET_ALLOC: state_in = ST_ALLOC_WR;
               RET_FLUSH: state_in = ST_FLUSH_CHK;
               RET_FINAL: state_in = ST_FINAL;
               default:   state_in = ST_FINAL;
            endcase
         end
         ST_FIND_RD: state_in = ST_FIND_DO;
         ST_FIND_DO: begin
            priority if (stat.found) begin
               state_in = ST_PART_RD;
            end else if (stat.resend) begin
               state_in = ST_STATUS;
            end else if (stat.ring_empty) begin
               own_in   = 1'b1;
               state_in = ST_ALLOC_CHK;
            end else begin
               state_in = ST_GAP_RD;
            end
         end
         ST_GAP_RD:   state_in = ST_GAP_INIT;
         ST_GAP_INIT: state_in = ST_GAP_CHK;
         ST_GAP_CHK: begin
            own_in   = stat.g_match;
            state_in = ST_ALLOC_CHK;
         end
         ST_ALLOC_CHK: begin
            if (stat.ring_full) begin
               ret_in   = RET_ALLOC;
               state_in = ST_DROP_RD;
            end else begin
               state_in = ST_ALLOC_WR;
            end
         end
         ST_ALLOC_WR: state_in = own_ff ? ST_SCAN_CHK : ST_GAP_EMIT;
         ST_GAP_EMIT: begin
            if (stat.nack_cap || stat.out_free) begin
               state_in = ST_GAP_CHK;
            end
         end
         ST_SCAN_CHK: state_in = stat.scan_more ? ST_SCAN_RD : ST_PART_RD;
         ST_SCAN_RD:  state_in = ST_SCAN_EMIT;
         ST_SCAN_EMIT: begin
            if (!stat.scan_need || stat.nack_cap || stat.out_free) begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_PART_RD: state_in = ST_PART_WR;
         ST_PART_WR: state_in = stat.sensor_bad ? ST_FLUSH_CHK : ST_FINAL;
         ST_FLUSH_CHK: begin
            ret_in   = stat.at_idx ? RET_FINAL : RET_FLUSH;
            state_in = ST_DROP_RD;
         end
         ST_FINAL: state_in = ST_STATUS;
         ST_STATUS: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_HEAD;
      cmd.alloc_own = own_ff;
      req_stall  = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE:  cmd.accept = req_valid;
         ST_PKT:   cmd.pkt_start = 1'b1;
         ST_WIN: begin
            if (stat.ready) begin
               if (stat.win_zero) begin
                  cmd.clr_ready = 1'b1;
               end else begin
                  cmd.win_dec = 1'b1;
               end
            end
         end
         ST_DROP_RD: cmd.rd_sel = RD_HEAD;
         ST_DROP_DO: cmd.drop_do = 1'b1;
         ST_FIND_RD: cmd.rd_sel = RD_LAST;
         ST_FIND_DO: cmd.find_do = 1'b1;
         ST_GAP_RD:  cmd.rd_sel = RD_HEAD;
         ST_GAP_INIT: cmd.gap_init = 1'b1;
         ST_GAP_CHK: begin
         end
         ST_ALLOC_CHK: cmd.alloc_full = stat.ring_full;
         ST_ALLOC_WR: begin
            cmd.alloc_wr  = 1'b1;
            cmd.scan_init = own_ff;
         end
         ST_GAP_EMIT: begin
            if (stat.nack_cap) begin
               cmd.set_over = 1'b1;
               cmd.g_inc    = 1'b1;
            end else if (stat.out_free) begin
               cmd.emit_gap = 1'b1;
               cmd.g_inc    = 1'b1;
            end
         end
         ST_SCAN_CHK: begin
         end
         ST_SCAN_RD: cmd.rd_sel = RD_SCAN;
         ST_SCAN_EMIT: begin
            cmd.rd_sel = RD_SCAN;
            if (!stat.scan_need) begin
               cmd.scan_inc = 1'b1;
            end else if (stat.nack_cap) begin
               cmd.set_over = 1'b1;
               cmd.scan_inc = 1'b1;
            end else if (stat.out_free) begin
               cmd.emit_scan = 1'b1;
               cmd.scan_inc  = 1'b1;
            end
         end
         ST_PART_RD: cmd.rd_sel = RD_IDX;
         ST_PART_WR: begin
            cmd.rd_sel  = RD_IDX;
            cmd.part_wr = 1'b1;
         end
         ST_FLUSH_CHK: begin
         end
         ST_FINAL:  cmd.final_chk = 1'b1;
         ST_STATUS: cmd.emit_status = stat.out_free;
         default: begin
         end
      endcase
   end

endmodule

// File: src/ssrb_datapath.sv
// ----------------------------------------------------------------------------
// ssrb_datapath
// Ring storage (ids, part masks, axis data), ring pointers, counters,
// configuration registers and the result register of the reassembly buffer.
// ----------------------------------------------------------------------------
module ssrb_datapath
   import ssrb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ssrb_req_type        req_data,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_index,
   input  logic [CSR_DW-1:0]   csr_wdata,
   input  ssrb_cmd_type        cmd,
   output ssrb_stat_type       stat,
   output logic                rsp_valid,
   output ssrb_rsp_type        rsp_data,
   input  logic                rsp_stall
);

   // configuration
   logic [7:0]  ws_ff, ws_in;
   logic [15:0] tmo_ff, tmo_in;
   logic [7:0]  reach_ff, reach_in;

   // control state
   logic [RING_AW-1:0] head_ff, head_in, tail_ff, tail_in, idx_ff, idx_in;
   logic [CMP_W-1:0]   rc_ff, rc_in, j_ff, j_in;
   logic               ready_ff, ready_in, first_ff, first_in, over_ff, over_in;
   logic [15:0]        idle_ff, idle_in;
   logic [2:0]         flags_ff, flags_in;
   logic [31:0]        rec_ff, rec_in, drop_ff, drop_in;
   logic [ID_WIDTH-1:0] g_ff, g_in;
   logic [7:0]         wcnt_ff, wcnt_in;
   logic [NACK_CW-1:0] ncnt_ff, ncnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload
   ssrb_req_type item_ff, item_in;
   ssrb_rsp_type rsp_data_ff, rsp_data_in;

   // memories and registered read data
   logic [3:0]            mask_mem [RING_DEPTH];
   logic [ID_WIDTH-1:0]   id_mem   [RING_DEPTH];
   logic [AXES_WIDTH-1:0] axis_mem [RING_DEPTH];
   logic [3:0]            mask_a_ff, mask_b_ff;
   logic [ID_WIDTH-1:0]   id_rd_ff;
   logic [AXES_WIDTH-1:0] axis_rd_ff;

   logic [RING_AW-1:0]    last, len, rd_addr, win_addr, off, scan_addr;
   logic [CMP_W-1:0]      win_sum, len_w, ws_w, reach_w;
   logic [ID_WIDTH-1:0]   back;
   logic                  empty, found_any;
   logic [3:0]            part_bit, new_mask;
   logic [AXES_WIDTH-1:0] merged;
   logic                  s1, s2, complete_new, out_free;
   logic                  mask_we, axis_we;
   logic [RING_AW-1:0]    mask_wa;
   logic [3:0]            mask_wd;

   assign last      = tail_ff - 1'b1;
   assign len       = tail_ff - head_ff;
   assign empty     = (head_ff == tail_ff);
   assign len_w     = CMP_W'(len);
   assign ws_w      = CMP_W'(ws_ff);
   assign reach_w   = CMP_W'(reach_ff);
   assign win_sum   = CMP_W'(head_ff) + ws_w;
   assign win_addr  = win_sum[RING_AW-1:0];
   assign scan_addr = idx_ff - j_ff[RING_AW-1:0];
   assign off       = idx_ff - head_ff;
   assign back      = id_rd_ff - item_ff.sample_id;
   assign found_any = !empty && (back < ID_WIDTH'(reach_ff)) && (back < ID_WIDTH'(len));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_HEAD: rd_addr = head_ff;
         RD_LAST: rd_addr = last;
         RD_IDX:  rd_addr = idx_ff;
         RD_SCAN: rd_addr = scan_addr;
         default: rd_addr = head_ff;
      endcase
   end

   // merge the arriving part into the stored sample for the sensor check
   always_comb begin
      merged = axis_rd_ff;
      merged[item_ff.part_kind * PART_WIDTH +: PART_WIDTH] =
         {item_ff.axis_z, item_ff.axis_y, item_ff.axis_x};
   end

   assign part_bit     = 4'b0001 << item_ff.part_kind;
   assign new_mask     = mask_a_ff | part_bit;
   assign complete_new = (mask_a_ff != ALL_PARTS) && (new_mask == ALL_PARTS);
   assign s1 = (merged[0 +: PART_WIDTH] == '0) && (merged[2*PART_WIDTH +: PART_WIDTH] == '0);
   assign s2 = (merged[PART_WIDTH +: PART_WIDTH] == '0) &&
               (merged[3*PART_WIDTH +: PART_WIDTH] == '0);

   always_comb begin
      stat.ready      = ready_ff;
      stat.win_zero   = (wcnt_ff == '0);
      stat.found      = found_any && (item_ff.is_resend || (back == '0));
      stat.resend     = item_ff.is_resend;
      stat.ring_empty = empty;
      stat.ring_full  = ((tail_ff + 1'b1) == head_ff);
      stat.g_match    = (g_ff == item_ff.sample_id);
      stat.scan_more  = (j_ff < reach_w) && (j_ff < len_w);
      stat.scan_need  = (mask_a_ff != ALL_PARTS);
      stat.nack_cap   = (ncnt_ff == NACK_CW'(NACK_CAP));
      stat.out_free   = out_free;
      stat.sensor_bad = complete_new && (s1 || s2);
      stat.at_idx     = (head_ff == idx_ff);
   end

   // memory write ports
   always_comb begin
      mask_we = cmd.alloc_wr || cmd.part_wr;
      mask_wa = cmd.alloc_wr ? tail_ff : idx_ff;
      mask_wd = cmd.alloc_wr ? 4'h0 : new_mask;
      axis_we = cmd.part_wr;
   end

   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[mask_wa] <= mask_wd;
      end
      if (cmd.alloc_wr) begin
         id_mem[tail_ff] <= cmd.alloc_own ? item_ff.sample_id : g_ff;
      end
      if (axis_we) begin
         axis_mem[idx_ff][item_ff.part_kind * PART_WIDTH +: PART_WIDTH] <=
            {item_ff.axis_z, item_ff.axis_y, item_ff.axis_x};
      end
      mask_a_ff  <= mask_mem[rd_addr];
      mask_b_ff  <= mask_mem[win_addr];
      id_rd_ff   <= id_mem[rd_addr];
      axis_rd_ff <= axis_mem[rd_addr];
   end

   // next values
   always_comb begin
      ws_in        = ws_ff;
      tmo_in       = tmo_ff;
      reach_in     = reach_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      idx_in       = idx_ff;
      rc_in        = rc_ff;
      j_in         = j_ff;
      ready_in     = ready_ff;
      first_in     = first_ff;
      over_in      = over_ff;
      idle_in      = idle_ff;
      flags_in     = flags_ff;
      rec_in       = rec_ff;
      drop_in      = drop_ff;
      g_in         = g_ff;
      wcnt_in      = wcnt_ff;
      ncnt_in      = ncnt_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE:  ws_in    = csr_wdata[7:0];
            CSR_TIMEOUT:      tmo_in   = csr_wdata[15:0];
            CSR_RESEND_REACH: reach_in = csr_wdata[7:0];
            default: begin
            end
         endcase
      end

      if (cmd.accept) begin
         item_in = req_data;
         ncnt_in = '0;
         over_in = 1'b0;
         if (req_data.opcode == OP_TICK && idle_ff != '1) begin
            idle_in = idle_ff + 1'b1;
         end
      end

      if (cmd.pkt_start) begin
         flags_in[0] = 1'b0;
         if (!first_ff && idle_ff >= tmo_ff) begin
            flags_in[0] = 1'b1;
            ready_in    = 1'b0;
            head_in     = '0;
            tail_in     = '0;
            rc_in       = '0;
         end
         idle_in  = '0;
         first_in = 1'b0;
         wcnt_in  = ws_ff;
      end

      if (cmd.win_dec) begin
         wcnt_in = wcnt_ff - 1'b1;
      end
      if (cmd.clr_ready) begin
         ready_in = 1'b0;
      end

      // evict oldest sample, keep the leading window's ready count
      if (cmd.drop_do && !empty) begin
         rc_in = rc_ff
               - CMP_W'((mask_a_ff == ALL_PARTS) && (rc_ff != '0))
               + CMP_W'((len_w > ws_w) && (mask_b_ff == ALL_PARTS));
         head_in = head_ff + 1'b1;
      end

      if (cmd.find_do) begin
         idx_in = last - back[RING_AW-1:0];
      end
      if (cmd.gap_init) begin
         g_in = id_rd_ff + ID_WIDTH'(len);
      end
      if (cmd.g_inc) begin
         g_in = g_ff + 1'b1;
      end
      if (cmd.alloc_full) begin
         drop_in = drop_ff + 1'b1;
      end
      if (cmd.alloc_wr) begin
         tail_in = tail_ff + 1'b1;
         if (cmd.alloc_own) begin
            idx_in = tail_ff;
         end
      end
      if (cmd.scan_init) begin
         j_in = CMP_W'(4);
      end
      if (cmd.scan_inc) begin
         j_in = j_ff + CMP_W'(4);
      end

      if (cmd.part_wr) begin
         if (item_ff.is_resend && ((mask_a_ff & part_bit) == 4'h0)) begin
            rec_in = rec_ff + 1'b1;
         end
         if (complete_new) begin
            if (CMP_W'(off) < ws_w) begin
               rc_in = rc_ff + 1'b1;
            end
            if (idx_ff == last) begin
               flags_in[2:1] = {s2, s1};
            end
            if (s1 || s2) begin
               flags_in[0] = 1'b1;
            end
         end
      end

      if (cmd.final_chk && rc_ff >= ws_w) begin
         ready_in = 1'b1;
      end

      if (cmd.set_over) begin
         over_in = 1'b1;
      end

      if (cmd.emit_gap || cmd.emit_scan) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in              = '0;
         rsp_data_in.result_kind  = RK_NACK;
         rsp_data_in.nack_id      = cmd.emit_gap ? g_ff : id_rd_ff;
         rsp_data_in.missing_mask = cmd.emit_gap ? ALL_PARTS : (~mask_a_ff & ALL_PARTS);
         ncnt_in                  = ncnt_ff + 1'b1;
      end

      if (cmd.emit_status) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.result_kind     = RK_STATUS;
         rsp_data_in.nack_id         = '0;
         rsp_data_in.missing_mask    = '0;
         rsp_data_in.window_ready    = ready_ff;
         rsp_data_in.link_lost       = flags_ff[0];
         rsp_data_in.sensor1_lost    = flags_ff[1];
         rsp_data_in.sensor2_lost    = flags_ff[2];
         rsp_data_in.recovered_count = rec_ff;
         rsp_data_in.dropped_count   = drop_ff;
         rsp_data_in.nack_overflow   = over_ff;
         rsp_data_in.last            = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff        <= 8'd32;
         tmo_ff       <= 16'd1000;
         reach_ff     <= 8'd200;
         head_ff      <= '0;
         tail_ff      <= '0;
         idx_ff       <= '0;
         rc_ff        <= '0;
         j_ff         <= '0;
         ready_ff     <= 1'b0;
         first_ff     <= 1'b1;
         over_ff      <= 1'b0;
         idle_ff      <= '0;
         flags_ff     <= '0;
         rec_ff       <= '0;
         drop_ff      <= '0;
         g_ff         <= '0;
         wcnt_ff      <= '0;
         ncnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ws_ff        <= ws_in;
         tmo_ff       <= tmo_in;
         reach_ff     <= reach_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         idx_ff       <= idx_in;
         rc_ff        <= rc_in;
         j_ff         <= j_in;
         ready_ff     <= ready_in;
         first_ff     <= first_in;
         over_ff      <= over_in;
         idle_ff      <= idle_in;
         flags_ff     <= flags_in;
         rec_ff       <= rec_in;
         drop_ff      <= drop_in;
         g_ff         <= g_in;
         wcnt_ff      <= wcnt_in;
         ncnt_ff      <= ncnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/sensor_sample_reassembly_buffer_core.sv
// ----------------------------------------------------------------------------
// sensor_sample_reassembly_buffer_core
// Reassembles sensor samples from part packets in a ring and requests the
// missing parts by NACK.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one part packet or one time tick per transaction. rsp_*
//   returns zero or more NACK transactions (at most 63) followed by one
//   status transaction with last set. csr_* writes window_size (0),
//   timeout_ticks (1) and resend_reach (2) while the block is idle.
// Timing: one transaction is worked at a time; req_stall is high from
//   acceptance until its status result is loaded. A packet's work depends
//   on whether its id is found, it is a stale resend that is dropped or it
//   opens a new slot, and grows with each sample dropped by window discard
//   or sensor-loss flush, each ring-full eviction, each skipped id opened
//   and each re-NACK candidate (every fourth older sample within
//   resend_reach, at most 63). The ring memories are read one address per
//   cycle with registered data.
// Reset: synchronous; the ring is empty and the registers take their reset
//   values. Ring contents are not cleared.
// Stall: a held rsp_stall freezes the result register; the sequencer waits
//   at the next emit, and the following request is accepted once the status
//   result of the current one is in the result register.
// ----------------------------------------------------------------------------
module sensor_sample_reassembly_buffer_core
   import ssrb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ssrb_req_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ssrb_rsp_type      rsp_data,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   ssrb_cmd_type  cmd;
   ssrb_stat_type stat;

   ssrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   ssrb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

// File: tb/tb_sensor_sample_reassembly_buffer_core.sv
// ----------------------------------------------------------------------------
// tb_sensor_sample_reassembly_buffer_core
// Self-checking bench for the sample reassembly ring. A behavioral copy of the
// ring (slots, part masks, window count, flags and counters) predicts the NACK
// and status transactions of every accepted request. Directed tests cover
// extreme fields, gaps, resends, sensor loss, the NACK cap, ring full, id wrap,
// timeout and the tick count at the timeout boundary. Random phases then drive
// well-formed sample streams mixed with resends, ticks and noise under varied
// idle and stall.
// ----------------------------------------------------------------------------
module tb_sensor_sample_reassembly_buffer_core;
   import ssrb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ssrb_req_type      req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ssrb_rsp_type      rsp_data;
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   sensor_sample_reassembly_buffer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("tb_sensor_sample_reassembly_buffer_core: done, errors");
      $finish;
   end

   // ---------------- ring predictor ----------------
   int unsigned win_size  = 32;
   int unsigned tmo_ticks = 1000;
   int unsigned reach     = 200;

   logic [15:0] slot_id [RING_DEPTH];
   logic [15:0] slot_axis [RING_DEPTH][4][3];
   logic [3:0]  slot_mask [RING_DEPTH];
   int unsigned head_ptr = 0, tail_ptr = 0, ready_cnt = 0, idle_cnt = 0;
   bit          window_full = 0, first_pkt = 1;
   bit [2:0]    flags = '0;
   bit [31:0]   recovered = '0, dropped = '0;
   int          nack_num;
   bit          nack_over;

   ssrb_rsp_type pending_results[$];
   int           error_count = 0;

   int send_idle_pct = 0;
   int stall_pct = 0;

   function automatic int unsigned ring_len();
      return (tail_ptr >= head_ptr) ? tail_ptr - head_ptr : tail_ptr + RING_DEPTH - head_ptr;
   endfunction

   function automatic int unsigned newest_slot();
      return (tail_ptr == 0) ? RING_DEPTH - 1 : tail_ptr - 1;
   endfunction

   function automatic void evict_oldest();
      int unsigned inc;
      if (head_ptr == tail_ptr) return;
      if (slot_mask[head_ptr] == ALL_PARTS && ready_cnt > 0) ready_cnt--;
      if (ring_len() > win_size) begin
         inc = (head_ptr + win_size) % RING_DEPTH;
         if (slot_mask[inc] == ALL_PARTS) ready_cnt++;
      end
      head_ptr = (head_ptr + 1) % RING_DEPTH;
   endfunction

   function automatic int unsigned open_slot(logic [15:0] id);
      int unsigned idx;
      if ((tail_ptr + 1) % RING_DEPTH == head_ptr) begin
         dropped++;
         evict_oldest();
      end
      idx = tail_ptr;
      slot_mask[idx] = '0;
      slot_id[idx] = id;
      tail_ptr = (tail_ptr + 1) % RING_DEPTH;
      return idx;
   endfunction

   function automatic void request_missing(int unsigned idx);
      ssrb_rsp_type n;
      if (slot_mask[idx] == ALL_PARTS) return;
      if (nack_num >= NACK_CAP) begin
         nack_over = 1;
         return;
      end
      n = '0;
      n.result_kind = RK_NACK;
      n.nack_id = slot_id[idx];
      n.missing_mask = ~slot_mask[idx];
      pending_results.push_back(n);
      nack_num++;
   endfunction

   function automatic bit locate_slot(logic [15:0] id, output int unsigned idx);
      int unsigned last;
      logic [15:0] back;
      idx = 0;
      if (head_ptr == tail_ptr) return 0;
      last = newest_slot();
      back = slot_id[last] - id;
      if (back >= reach || back > ring_len() - 1) return 0;
      idx = (last + RING_DEPTH - (back % RING_DEPTH)) % RING_DEPTH;
      return 1;
   endfunction

   function automatic bit sensor_all_zero(int unsigned idx, int a, int b);
      for (int k = 0; k < 3; k++)
         if (slot_axis[idx][a][k] != 0 || slot_axis[idx][b][k] != 0) return 0;
      return 1;
   endfunction

   function automatic void apply_packet(ssrb_req_type r);
      int unsigned idx, len, off, i, j;
      logic [3:0]  prev, pbit;
      logic [15:0] g;
      bit          hit, s1, s2;
      flags[0] = 0;
      if (!first_pkt && idle_cnt >= tmo_ticks) begin
         flags[0] = 1;
         window_full = 0;
         head_ptr = 0;
         tail_ptr = 0;
         ready_cnt = 0;
      end
      idle_cnt = 0;
      first_pkt = 0;
      if (window_full) begin
         for (i = 0; i < win_size; i++) evict_oldest();
         window_full = 0;
      end
      hit = locate_slot(r.sample_id, idx);
      if (!r.is_resend && hit && idx != newest_slot()) hit = 0;
      if (!hit) begin
         if (r.is_resend) return;
         len = ring_len();
         if (len > 0) begin
            g = slot_id[head_ptr] + 16'(len);
            while (g != r.sample_id) begin
               request_missing(open_slot(g));
               g = g + 16'd1;
            end
         end
         idx = open_slot(r.sample_id);
         len = ring_len();
         i = idx;
         // re-request every fourth older sample within reach
         for (j = 0; j < reach && j < len; j++) begin
            if (j % 4 == 0 && i != idx) request_missing(i);
            i = (i == 0) ? RING_DEPTH - 1 : i - 1;
         end
      end
      prev = slot_mask[idx];
      pbit = 4'b1 << r.part_kind;
      if (r.is_resend && !(prev & pbit)) recovered++;
      slot_axis[idx][r.part_kind][0] = r.axis_x;
      slot_axis[idx][r.part_kind][1] = r.axis_y;
      slot_axis[idx][r.part_kind][2] = r.axis_z;
      slot_mask[idx] = prev | pbit;
      off = (idx >= head_ptr) ? idx - head_ptr : idx + RING_DEPTH - head_ptr;
      if (prev != ALL_PARTS && slot_mask[idx] == ALL_PARTS) begin
         s1 = sensor_all_zero(idx, 0, 2);
         s2 = sensor_all_zero(idx, 1, 3);
         if (off < win_size) ready_cnt++;
         if (idx == newest_slot()) flags = {s2, s1, flags[0]};
         if (s1 || s2) begin
            flags[0] = 1;
            for (i = 0; i < RING_DEPTH && head_ptr != idx; i++) evict_oldest();
            evict_oldest();
         end
      end
      if (ready_cnt >= win_size) window_full = 1;
   endfunction

   function automatic void predict_ring_outputs(ssrb_req_type r);
      ssrb_rsp_type s;
      nack_num = 0;
      nack_over = 0;
      if (r.opcode == OP_TICK) begin
         if (idle_cnt < 65535) idle_cnt++;
      end else begin
         apply_packet(r);
      end
      s = '0;
      s.result_kind = RK_STATUS;
      s.window_ready = window_full;
      s.link_lost = flags[0];
      s.sensor1_lost = flags[1];
      s.sensor2_lost = flags[2];
      s.recovered_count = recovered;
      s.dropped_count = dropped;
      s.nack_overflow = nack_over;
      s.last = 1'b1;
      pending_results.push_back(s);
   endfunction

   // ---------------- result checking ----------------
   function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   always begin : result_monitor
      bit           fire;
      ssrb_rsp_type got, want;
      @(negedge clock);
      fire = rsp_valid === 1'b1 && rsp_stall === 1'b0;
      got = rsp_data;
      @(posedge clock);
      if (!reset && fire) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction %h", got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            cmp_field("result_kind", want.result_kind, got.result_kind);
            cmp_field("nack_id", want.nack_id, got.nack_id);
            cmp_field("missing_mask", want.missing_mask, got.missing_mask);
            cmp_field("window_ready", want.window_ready, got.window_ready);
            cmp_field("link_lost", want.link_lost, got.link_lost);
            cmp_field("sensor1_lost", want.sensor1_lost, got.sensor1_lost);
            cmp_field("sensor2_lost", want.sensor2_lost, got.sensor2_lost);
            cmp_field("recovered_count", want.recovered_count, got.recovered_count);
            cmp_field("dropped_count", want.dropped_count, got.dropped_count);
            cmp_field("nack_overflow", want.nack_overflow, got.nack_overflow);
            cmp_field("last", want.last, got.last);
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // ---------------- stimulus helpers ----------------
   function automatic logic [15:0] rnd16();
      return 16'($urandom);
   endfunction

   function automatic ssrb_req_type part_pkt(logic [1:0] kind, logic rs, logic [15:0] id,
                                             logic [15:0] x, logic [15:0] y, logic [15:0] z);
      ssrb_req_type r;
      r = '0;
      r.opcode = OP_PART;
      r.part_kind = kind;
      r.is_resend = rs;
      r.sample_id = id;
      r.axis_x = x;
      r.axis_y = y;
      r.axis_z = z;
      return r;
   endfunction

   function automatic ssrb_req_type tick_pkt();
      ssrb_req_type r;
      r = ssrb_req_type'($bits(ssrb_req_type)'({$urandom, $urandom, $urandom}));
      r.opcode = OP_TICK;
      return r;
   endfunction

   task automatic send_item(ssrb_req_type r);
      bit go;
      req_valid <= 1'b1;
      req_data <= r;
      forever begin
         @(negedge clock);
         go = req_stall === 1'b0;
         @(posedge clock);
         if (go) break;
      end
      predict_ring_outputs(r);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // hold the sender until every pending result has drained
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WINDOW_SIZE:  win_size = val & 8'hFF;
         CSR_TIMEOUT:      tmo_ticks = val & 16'hFFFF;
         CSR_RESEND_REACH: reach = val & 8'hFF;
         default: ;
      endcase
   endtask

   // ---------------- tests ----------------
   task automatic test_directed();
      send_item(part_pkt(0, 0, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF));
      send_item(part_pkt(1, 0, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000));
      send_item(part_pkt(2, 0, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555));
      send_item(part_pkt(3, 0, 16'h0000, 16'hAAAA, 16'hFFFF, 16'h0001));
      send_item(part_pkt(0, 0, 16'h0000, 16'h1234, 16'h1234, 16'h1234));
      send_item(part_pkt(0, 0, 16'h0004, 16'h0101, 16'h0202, 16'h0303));
      send_item(part_pkt(1, 1, 16'h0002, 16'h0011, 16'h0022, 16'h0033));
      send_item(part_pkt(1, 1, 16'h0002, 16'h0044, 16'h0055, 16'h0066));
      send_item(part_pkt(2, 1, 16'h9000, 16'h0001, 16'h0001, 16'h0001));
      // sample 5 with the first sensor all zero
      send_item(part_pkt(0, 0, 16'h0005, 16'h0000, 16'h0000, 16'h0000));
      send_item(part_pkt(1, 0, 16'h0005, 16'h0007, 16'h0000, 16'h0000));
      send_item(part_pkt(2, 0, 16'h0005, 16'h0000, 16'h0000, 16'h0000));
      send_item(part_pkt(3, 0, 16'h0005, 16'h0000, 16'h0009, 16'h0000));
      // sample 6 with the second sensor all zero
      send_item(part_pkt(1, 0, 16'h0006, 16'h0000, 16'h0000, 16'h0000));
      send_item(part_pkt(3, 0, 16'h0006, 16'h0000, 16'h0000, 16'h0000));
      send_item(part_pkt(0, 0, 16'h0006, 16'h0003, 16'h0000, 16'h0000));
      send_item(part_pkt(2, 0, 16'h0006, 16'h0000, 16'h0000, 16'h0004));
      send_item(tick_pkt());
      // sample 100 opens a slot in the ring emptied by the sensor-loss flush
      send_item(part_pkt(2, 0, 16'd100, 16'h0F0F, 16'hF0F0, 16'h00FF));
      send_item(part_pkt(3, 1, 16'd40, 16'hFF00, 16'h0F0F, 16'hF0F0));
      // gap longer than the ring passes the NACK cap and forces evictions
      send_item(part_pkt(0, 0, 16'd420, 16'h2222, 16'h3333, 16'h4444));
      drain();
   endtask

   task automatic test_timeout_and_wrap();
      write_reg(CSR_TIMEOUT, 3);
      repeat (3) send_item(tick_pkt());
      send_item(part_pkt(1, 0, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_item(part_pkt(2, 0, 16'h0001, 16'h8000, 16'h8000, 16'h8000));
      // first send of an older id wraps through the whole id space
      send_item(part_pkt(3, 0, 16'hFFFE, 16'h1111, 16'h1111, 16'h1111));
      drain();
   endtask

   task automatic test_reg_extremes();
      write_reg(CSR_WINDOW_SIZE, 1);
      write_reg(CSR_RESEND_REACH, 1);
      write_reg(CSR_TIMEOUT, 1);
      send_item(tick_pkt());
      for (int p = 0; p < 4; p++)
         send_item(part_pkt(2'(p), 0, 16'h0300, rnd16(), rnd16(), rnd16()));
      send_item(part_pkt(0, 0, 16'h0302, rnd16(), rnd16(), rnd16()));
      send_item(part_pkt(1, 1, 16'h0301, rnd16(), rnd16(), rnd16()));
      send_item(part_pkt(1, 0, 16'h0302, rnd16(), rnd16(), rnd16()));
      send_item(tick_pkt());
      send_item(part_pkt(2, 0, 16'h0302, rnd16(), rnd16(), rnd16()));
      write_reg(CSR_WINDOW_SIZE, 0);
      write_reg(CSR_RESEND_REACH, 0);
      write_reg(CSR_TIMEOUT, 0);
      for (int k = 0; k < 4; k++)
         send_item(part_pkt(2'(k), k[0], rnd16(), rnd16(), rnd16(), rnd16()));
      write_reg(CSR_WINDOW_SIZE, 255);
      write_reg(CSR_RESEND_REACH, 255);
      write_reg(CSR_TIMEOUT, 65535);
      for (int n = 0; n < 300; n += 3)
         send_item(part_pkt(2'(n % 4), 0, 16'(16'h5000 + n), rnd16(), rnd16(), rnd16()));
      drain();
   endtask

   task automatic test_tick_timeout();
      // one tick short of the timeout keeps the ring, a full count resets it
      write_reg(CSR_TIMEOUT, 5);
      send_item(part_pkt(0, 0, 16'h7000, 16'h0001, 16'h0002, 16'h0003));
      repeat (4) send_item(tick_pkt());
      send_item(part_pkt(1, 0, 16'h7001, 16'h0004, 16'h0005, 16'h0006));
      repeat (5) send_item(tick_pkt());
      send_item(part_pkt(2, 0, 16'h7002, 16'h0007, 16'h0008, 16'h0009));
      drain();
   endtask

   task automatic test_random_stream(int idle_p, int stall_p, int target);
      logic [15:0] cur_id;
      logic [3:0]  sent;
      int          lost, count, roll, p;
      logic [15:0] ax [3];
      send_idle_pct = idle_p;
      stall_pct = stall_p;
      write_reg(CSR_WINDOW_SIZE, $urandom_range(2, 8));
      write_reg(CSR_RESEND_REACH, $urandom_range(1, 255));
      write_reg(CSR_TIMEOUT, 8);
      // flush any leftover ring before a fresh base id
      repeat (9) send_item(tick_pkt());
      cur_id = rnd16();
      sent = '0;
      lost = 0;
      count = 0;
      while (count < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            send_item(tick_pkt());
            count++;
         end else if (roll < 6) begin
            repeat (9) send_item(tick_pkt());
            cur_id = rnd16();
            sent = ALL_PARTS;
            count += 9;
         end else if (roll < 20) begin
            send_item(part_pkt(2'($urandom), 1, cur_id - 16'($urandom_range(0, 24)),
                               rnd16(), rnd16(), rnd16()));
            count++;
         end else if (roll < 24) begin
            if (roll[0])
               send_item(part_pkt(2'($urandom), 1, rnd16(), rnd16(), rnd16(), rnd16()));
            else
               send_item(part_pkt(2'($urandom), 0, cur_id, rnd16(), rnd16(), rnd16()));
            count++;
         end else begin
            if (sent == ALL_PARTS) begin
               cur_id += ($urandom_range(0, 9) == 0) ? 16'($urandom_range(2, 5)) : 16'd1;
               sent = '0;
               lost = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 2) : 0;
            end
            do p = $urandom_range(0, 3); while (sent[p]);
            sent[p] = 1'b1;
            foreach (ax[k]) ax[k] = rnd16();
            // loss on sensor one zeroes acc1/gyro1, on sensor two acc2/gyro2
            if (lost != 0 && (p % 2) == lost - 1) foreach (ax[k]) ax[k] = '0;
            send_item(part_pkt(2'(p), 0, cur_id, ax[0], ax[1], ax[2]));
            count++;
         end
      end
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_timeout_and_wrap();
      send_idle_pct = 30;
      stall_pct = 30;
      test_reg_extremes();
      send_idle_pct = 0;
      stall_pct = 0;
      test_tick_timeout();
      test_random_stream(0, 0, 48);
      test_random_stream(67, 0, 48);
      test_random_stream(0, 67, 48);
      test_random_stream(30, 30, 48);
      drain();
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("tb_sensor_sample_reassembly_buffer_core: done, clean");
      else
         $display("tb_sensor_sample_reassembly_buffer_core: done, errors");
      $finish;
   end

endmodule

// File: sensor_sample_reassembly_buffer_core.f
src/ssrb_pkg.sv
src/ssrb_ctrl.sv
src/ssrb_datapath.sv
src/sensor_sample_reassembly_buffer_core.sv
tb/tb_sensor_sample_reassembly_buffer_core.sv
